/* src/lru_key_value_cache_core_macros.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define LKVC_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies an expression in the next.
`define LKVC_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

/* src/lkvc_pkg.sv */
// Constants shared by the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int ADDR_W  = 3;

    localparam logic       REQ_GET = 1'b0;
    localparam logic       REQ_SET = 1'b1;

    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage

/* src/lru_key_value_cache_core.sv */
// LRU key-value cache: 16-entry fully associative store with one shared key comparator.
// Sequence: the walk over all entries, then finishing the last compare, picking the slot and
// committing, then the result cycle, which can already take the next start; busy stays high
// until then, so a new request is not taken while one is in flight.
// Results cannot be stalled; done is high for exactly one cycle per request.
// Reset (rst_n, async low) empties the cache and sets cap_reg to 16; no sweep needed.
`include "lru_key_value_cache_core_macros.svh"

module lru_key_value_cache_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // request beat
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] write_value,
    // result beat
    output logic                               done,
    output logic                               hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
    output logic                               evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0] evicted_key,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic        [lkvc_pkg::ADDR_W-1:0] paddr,
    input  logic        [31:0]                 pwdata,
    output logic        [31:0]                 prdata,
    output logic                               pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_LAST   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    localparam int IW = lkvc_pkg::IDX_W;
    localparam int CW = lkvc_pkg::CNT_W;
    localparam int DW = lkvc_pkg::DATA_W;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg;
    logic          req_set_reg;
    logic [DW-1:0] req_key_reg;
    logic [DW-1:0] req_val_reg;

    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [lkvc_pkg::CAP_W-1:0] cap_eff;

    logic [lkvc_pkg::ENTRIES-1:0] valid_reg;
    logic [IW-1:0] rank_reg [lkvc_pkg::ENTRIES];
    logic [CW-1:0] used_reg;

    logic [DW-1:0] key_mem [lkvc_pkg::ENTRIES];
    logic [DW-1:0] val_mem [lkvc_pkg::ENTRIES];
    logic [DW-1:0] key_rd_reg;
    logic [DW-1:0] val_rd_reg;
    logic [IW-1:0] rd_addr;

    // scan trackers
    logic          cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          found_reg;
    logic [IW-1:0] match_reg;
    logic          any_reg;
    logic [IW-1:0] worst_rank_reg;
    logic [IW-1:0] worst_slot_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_slot_reg;

    logic          evict_c;
    logic [IW-1:0] slot_c;
    logic [IW-1:0] slot_reg;
    logic          evict_reg;
    logic [IW-1:0] hit_rank;

    logic          done_reg;
    logic          hit_reg;
    logic [DW-1:0] read_value_reg;
    logic          evicted_reg;
    logic [DW-1:0] evicted_key_reg;

    logic          cfg_wr;

    assign busy   = (state_reg != ST_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lkvc_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY) ? {27'd0, cap_reg} : 32'd0;

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = lkvc_pkg::CAP_W'(1);
        end
        else if (cap_reg > lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES))
        begin
            cap_eff = lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // slot choice once the walk is complete
    always_comb
    begin
        evict_c = (req_set_reg == lkvc_pkg::REQ_SET) && !found_reg
                  && (used_reg >= CW'(cap_eff)) && any_reg;
        priority if (found_reg)
        begin
            slot_c = match_reg;
        end
        else if (evict_c)
        begin
            slot_c = worst_slot_reg;
        end
        else
        begin
            slot_c = free_slot_reg;
        end
    end

    assign rd_addr  = (state_reg == ST_SCAN) ? idx_reg : slot_c;
    assign hit_rank = rank_reg[slot_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SCAN;
            ST_SCAN:   if (idx_reg == IW'(lkvc_pkg::ENTRIES - 1)) state_next = ST_LAST;
            ST_LAST:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // key and value stores: one read port, one write port each
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
        if (state_reg == ST_COMMIT && req_set_reg == lkvc_pkg::REQ_SET)
        begin
            val_mem[slot_reg] <= req_val_reg;
            if (!found_reg)
            begin
                key_mem[slot_reg] <= req_key_reg;
            end
        end
    end

    // request and slot payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_set_reg <= req_type;
            req_key_reg <= lookup_key;
            req_val_reg <= write_value;
        end
        if (state_reg == ST_DECIDE)
        begin
            slot_reg  <= slot_c;
            evict_reg <= evict_c;
        end
        cmp_idx_reg <= idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            cap_reg         <= lkvc_pkg::CAP_RESET;
            valid_reg       <= '0;
            rank_reg        <= '{default: '0};
            used_reg        <= '0;
            cmp_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            match_reg       <= '0;
            any_reg         <= 1'b0;
            worst_rank_reg  <= '0;
            worst_slot_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            read_value_reg  <= '0;
            evicted_reg     <= 1'b0;
            evicted_key_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= (state_reg == ST_COMMIT);
            cmp_vld_reg <= (state_reg == ST_SCAN);

            if (cfg_wr)
            begin
                cap_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
            end

            if (state_reg == ST_IDLE && start)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                any_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + IW'(1);
            end

            // one entry per cycle through the shared comparator
            if (cmp_vld_reg)
            begin
                if (valid_reg[cmp_idx_reg])
                begin
                    if (!found_reg && key_rd_reg == req_key_reg)
                    begin
                        found_reg <= 1'b1;
                        match_reg <= cmp_idx_reg;
                    end
                    if (!any_reg || rank_reg[cmp_idx_reg] > worst_rank_reg)
                    begin
                        any_reg        <= 1'b1;
                        worst_rank_reg <= rank_reg[cmp_idx_reg];
                        worst_slot_reg <= cmp_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= cmp_idx_reg;
                end
            end

            if (state_reg == ST_COMMIT)
            begin
                hit_reg         <= found_reg;
                evicted_reg     <= evict_reg;
                evicted_key_reg <= evict_reg ? key_rd_reg : '0;
                if (req_set_reg == lkvc_pkg::REQ_SET)
                begin
                    read_value_reg <= '0;
                end
                else
                begin
                    read_value_reg <= found_reg ? val_rd_reg : lkvc_pkg::MISS_VALUE;
                end

                if (found_reg)
                begin
                    // promote: entries more recent than the hit age by one
                    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] < hit_rank)
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    rank_reg[slot_reg] <= '0;
                end
                else if (req_set_reg == lkvc_pkg::REQ_SET)
                begin
                    // insert: every other valid entry ages, new one is most recent
                    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                    begin
                        if (valid_reg[i] && IW'(i) != slot_reg)
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    rank_reg[slot_reg]  <= '0;
                    valid_reg[slot_reg] <= 1'b1;
                    if (!evict_reg)
                    begin
                        used_reg <= used_reg + CW'(1);
                    end
                end
            end
        end
    end

    `LKVC_ASSERT_ALWAYS(a_used_matches_valid, $countones(valid_reg) == used_reg,
        "occupancy count out of step with valid bits")
    `LKVC_ASSERT_ALWAYS(a_used_bounded, used_reg <= CW'(lkvc_pkg::ENTRIES),
        "occupancy above entry count")
    `LKVC_ASSERT_NEXT(a_commit_strobes, state_reg == ST_COMMIT,
        done_reg && state_reg == ST_IDLE, "commit did not produce a result beat")
    `LKVC_ASSERT_ALWAYS(a_evict_only_on_miss, !(done_reg && evicted_reg && hit_reg),
        "eviction reported on a hit")
    `LKVC_ASSERT_NEXT(a_start_scans, start && !busy,
        state_reg == ST_SCAN && idx_reg == '0, "accepted request did not start the walk")

endmodule
